[rtl/keq_pkg.sv]
package keq_pkg;

    localparam int QueueDepthDefault = 16;

    localparam int KeyWidth = 32;

    // The last key remembered after reset is the enter key.
    localparam logic [KeyWidth-1:0] ENTER_KEY_CODE = 32'd10;

    // Operation codes.
    localparam logic [1:0] OP_CLICK  = 2'd0;
    localparam logic [1:0] OP_SINGLE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NO_ROOM = 2'd2;

    typedef struct packed {
        logic [KeyWidth-1:0] key;
        logic                pressed;
    } event_t;

endpackage

[rtl/keq_event_ram.sv]
module keq_event_ram
    import keq_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  event_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output event_t        rd_data
);

    event_t mem [DEPTH];
    event_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/key_event_queue_unit.sv]
// Ring queue of key events held in a single-port-write, single-port-read memory with a
// registered read. Single pushes, clears, rejected pushes and reads of an empty queue
// load their result from the idle state. A click passes through S_CLICK as its press
// and release go through the one write port one after the other, and a read of a stored
// event passes through S_READ as the memory read is registered. One operation is in
// progress at a time; a new one is taken only when the output register is empty or its
// result is being transferred out in the same cycle, so a stalled result holds off the
// input. The queue is usable directly after reset with no clearing pass.
module key_event_queue_unit
    import keq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [KeyWidth-1:0] key_code,
    input  logic                key_pressed,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [KeyWidth-1:0] read_key,
    output logic                read_pressed,
    output logic                more_pending
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PW-1:0] PTR_LAST  = PW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
    localparam logic [FW-1:0] FILL_PAIR = FW'(QUEUE_DEPTH - 2);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLICK = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    logic [1:0]          state_reg,    state_next;
    logic [PW-1:0]       rd_ptr_reg,   rd_ptr_next;
    logic [PW-1:0]       wr_ptr_reg,   wr_ptr_next;
    logic [FW-1:0]       fill_reg,     fill_next;
    logic [KeyWidth-1:0] last_key_reg, last_key_next;
    logic [KeyWidth-1:0] click_key_reg, click_key_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg,   status_next;
    logic [KeyWidth-1:0] rkey_reg,     rkey_next;
    logic                rpressed_reg, rpressed_next;
    logic                more_reg,     more_next;

    logic          accept;
    logic          res_load;
    logic [PW-1:0] rd_ptr_inc;
    logic [PW-1:0] wr_ptr_inc;
    logic          ram_wr_en;
    event_t        ram_wr_data;
    logic          ram_rd_en;
    event_t        ram_rd_data;

    keq_event_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (PW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        last_key_next  = last_key_reg;
        click_key_next = click_key_reg;
        ram_wr_en      = 1'b0;
        ram_wr_data    = '{key: key_code, pressed: key_pressed};
        ram_rd_en      = 1'b0;
        res_load       = 1'b0;
        status_next    = ST_OK;
        rkey_next      = '0;
        rpressed_next  = 1'b0;
        more_next      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_CLICK:
                        begin
                            if (key_code == '0)
                            begin
                                res_load    = 1'b1;
                                status_next = ST_INVALID;
                            end
                            else if (fill_reg > FILL_PAIR)
                            begin
                                res_load    = 1'b1;
                                status_next = ST_NO_ROOM;
                            end
                            else
                            begin
                                // The press goes in now, the release in the next cycle.
                                ram_wr_en      = 1'b1;
                                ram_wr_data    = '{key: key_code, pressed: 1'b1};
                                wr_ptr_next    = wr_ptr_inc;
                                fill_next      = fill_reg + 1'b1;
                                click_key_next = key_code;
                                state_next     = S_CLICK;
                            end
                        end
                        OP_SINGLE:
                        begin
                            res_load = 1'b1;
                            if (key_code == '0)
                            begin
                                status_next = ST_INVALID;
                            end
                            else if (fill_reg == FILL_FULL)
                            begin
                                status_next = ST_NO_ROOM;
                            end
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                wr_ptr_next = wr_ptr_inc;
                                fill_next   = fill_reg + 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (fill_reg != '0)
                            begin
                                ram_rd_en   = 1'b1;
                                rd_ptr_next = rd_ptr_inc;
                                fill_next   = fill_reg - 1'b1;
                                state_next  = S_READ;
                            end
                            else
                            begin
                                res_load  = 1'b1;
                                rkey_next = last_key_reg;
                            end
                        end
                        OP_CLEAR:
                        begin
                            res_load    = 1'b1;
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            fill_next   = '0;
                        end
                    endcase
                end
            end
            S_CLICK:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '{key: click_key_reg, pressed: 1'b0};
                wr_ptr_next = wr_ptr_inc;
                fill_next   = fill_reg + 1'b1;
                res_load    = 1'b1;
                state_next  = S_IDLE;
            end
            S_READ:
            begin
                // The fill count was already lowered when the read was issued.
                res_load      = 1'b1;
                rkey_next     = ram_rd_data.key;
                rpressed_next = ram_rd_data.pressed;
                more_next     = (fill_reg != '0);
                last_key_next = ram_rd_data.key;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            last_key_reg  <= ENTER_KEY_CODE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            last_key_reg  <= last_key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        click_key_reg <= click_key_next;
        if (res_load)
        begin
            status_reg   <= status_next;
            rkey_reg     <= rkey_next;
            rpressed_reg <= rpressed_next;
            more_reg     <= more_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign read_key     = rkey_reg;
    assign read_pressed = rpressed_reg;
    assign more_pending = more_reg;

endmodule
